FILE: rtl/core/ttf_pkg.sv
// shared types, widths and codes of the triangle tangent frame block
package ttf_pkg;

    localparam int UNIT_FRAC_BITS_DEF = 14;

    localparam int COORD_W    = 32;
    localparam int UNIT_W     = 16;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 67;
    localparam int RED_W      = 31;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = 32;

    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] COMP_LAST   = 2'd2;
    localparam logic [2:0] STEP_T_LAST = 3'd7;
    localparam logic [2:0] STEP_LAST   = 3'd5;

    typedef enum logic [1:0] {
        PASS_T,
        PASS_B,
        PASS_N
    } t_pass;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [UNIT_W-1:0] tangent_x;
        logic signed [UNIT_W-1:0] tangent_y;
        logic signed [UNIT_W-1:0] tangent_z;
        logic signed [UNIT_W-1:0] binormal_x;
        logic signed [UNIT_W-1:0] binormal_y;
        logic signed [UNIT_W-1:0] binormal_z;
        logic signed [UNIT_W-1:0] normal_x;
        logic signed [UNIT_W-1:0] normal_y;
        logic signed [UNIT_W-1:0] normal_z;
        logic                     degenerate;
    } t_frame;

    typedef struct packed {
        logic       load;
        logic [1:0] corner;
        logic       mul;
        t_pass      pass;
        logic [2:0] step;
        logic       sq;
        logic [1:0] k;
        logic       red_init;
        logic       red_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       fix_sign;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic red_done;
    } t_sts;

endpackage

FILE: rtl/core/ttf_vtx_if.sv
// vertex channel: valid, ready and one vertex item
interface ttf_vtx_if;
    import ttf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: rtl/core/ttf_frm_if.sv
// frame channel: valid, ready and one tangent frame item
interface ttf_frm_if;
    import ttf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [UNIT_W-1:0] tangent_x;
    logic signed [UNIT_W-1:0] tangent_y;
    logic signed [UNIT_W-1:0] tangent_z;
    logic signed [UNIT_W-1:0] binormal_x;
    logic signed [UNIT_W-1:0] binormal_y;
    logic signed [UNIT_W-1:0] binormal_z;
    logic signed [UNIT_W-1:0] normal_x;
    logic signed [UNIT_W-1:0] normal_y;
    logic signed [UNIT_W-1:0] normal_z;
    logic                     degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                    binormal_z, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                  binormal_z, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: rtl/core/ttf_dp.sv
// datapath: corners, shared multiplier, reduction, square root and divider
module ttf_dp #(
    parameter int UNIT_FRAC_BITS = ttf_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttf_pkg::t_cmd    i_cmd,
    input  ttf_pkg::t_vertex i_vtx,
    output ttf_pkg::t_sts    o_sts,
    output ttf_pkg::t_frame  o_frame
);
    import ttf_pkg::*;

    localparam int QW = UNIT_FRAC_BITS + 1;
    localparam int VW = UNIT_FRAC_BITS + 2;
    localparam int DW = LEN_W + UNIT_FRAC_BITS;

    logic signed [COORD_W-1:0] w_pos [3];
    logic signed [COORD_W-1:0] r_pos1 [3];
    logic signed [COORD_W-1:0] r_pos2 [3];
    logic signed [COORD_W-1:0] r_u1, r_v1, r_u2, r_v2;

    logic signed [DIFF_W-1:0] r_e1 [3];
    logic signed [DIFF_W-1:0] r_e2 [3];
    logic signed [DIFF_W-1:0] r_du1, r_dv1, r_du2, r_dv2;

    logic signed [DIFF_W-1:0] w_a, w_b;
    logic [1:0]               w_i, w_ia, w_ib;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_psq;
    logic [2:0]               r_pstep;
    logic [1:0]               r_pk;

    logic signed [ACC_W-1:0] r_vec [3];
    logic signed [ACC_W-1:0] r_det;
    logic [SUM_W-1:0]        r_sum;

    logic [ACC_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [ACC_W-1:0] w_or;

    logic [SUM_W-1:0] r_rad, r_root, r_bit, w_trial;
    logic [LEN_W-1:0] w_len;

    logic [DW-1:0]        r_drem, r_dsor;
    logic [QW-1:0]        r_quo;
    logic                 w_ge;
    logic signed [VW-1:0] w_q;

    logic signed [VW-1:0] r_t [3];
    logic signed [VW-1:0] r_b [3];
    logic signed [VW-1:0] r_n [3];
    logic                 r_degen;
    t_frame               r_frame;

    assign w_pos[0] = i_vtx.pos_x;
    assign w_pos[1] = i_vtx.pos_y;
    assign w_pos[2] = i_vtx.pos_z;

    // operand selection for the shared multiplier
    always_comb begin
        w_i  = i_cmd.step[2:1];
        w_ia = (w_i == 2'd2) ? 2'd0 : w_i + 2'd1;
        w_ib = (w_i == 2'd0) ? 2'd2 : w_i - 2'd1;
        w_a  = '0;
        w_b  = '0;
        if (i_cmd.sq) begin
            w_a = $signed({2'b00, r_mag[i_cmd.k][RED_W-1:0]});
            w_b = w_a;
        end else begin
            case (i_cmd.pass)
                PASS_T: begin
                    if (i_cmd.step[2:1] == 2'd3) begin
                        w_a = i_cmd.step[0] ? r_du2 : r_du1;
                        w_b = i_cmd.step[0] ? r_dv1 : r_dv2;
                    end else begin
                        w_a = i_cmd.step[0] ? r_dv1 : r_dv2;
                        w_b = i_cmd.step[0] ? r_e2[w_i] : r_e1[w_i];
                    end
                end
                PASS_B: begin
                    w_a = i_cmd.step[0] ? r_du2 : r_du1;
                    w_b = i_cmd.step[0] ? r_e1[w_i] : r_e2[w_i];
                end
                PASS_N: begin
                    w_a = DIFF_W'(i_cmd.step[0] ? r_t[w_ib] : r_t[w_ia]);
                    w_b = DIFF_W'(i_cmd.step[0] ? r_b[w_ia] : r_b[w_ib]);
                end
                default: begin
                    w_a = '0;
                    w_b = '0;
                end
            endcase
        end
    end

    assign w_or    = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_trial = r_root + r_bit;
    assign w_len   = r_root[LEN_W-1:0];
    assign w_ge    = (r_drem >= r_dsor);
    assign w_q     = r_neg[i_cmd.k] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    assign o_sts.red_done = ~|w_or[ACC_W-1:RED_W];
    assign o_frame        = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul | i_cmd.sq;
        end
    end

    always_ff @(posedge i_clk) begin
        // corner capture and edge set-up
        if (i_cmd.load) begin
            case (i_cmd.corner)
                2'd0: begin
                    for (int i = 0; i < 3; i++) r_pos1[i] <= w_pos[i];
                    r_u1 <= i_vtx.tex_u;
                    r_v1 <= i_vtx.tex_v;
                end
                2'd1: begin
                    for (int i = 0; i < 3; i++) r_pos2[i] <= w_pos[i];
                    r_u2 <= i_vtx.tex_u;
                    r_v2 <= i_vtx.tex_v;
                end
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= DIFF_W'(r_pos2[i]) - DIFF_W'(r_pos1[i]);
                        r_e2[i] <= DIFF_W'(w_pos[i]) - DIFF_W'(r_pos1[i]);
                    end
                    r_du1   <= DIFF_W'(r_u2) - DIFF_W'(r_u1);
                    r_dv1   <= DIFF_W'(r_v2) - DIFF_W'(r_v1);
                    r_du2   <= DIFF_W'(i_vtx.tex_u) - DIFF_W'(r_u1);
                    r_dv2   <= DIFF_W'(i_vtx.tex_v) - DIFF_W'(r_v1);
                    r_degen <= 1'b0;
                end
            endcase
        end

        // multiplier stage, product registered and accumulated in the cycle after
        r_prod  <= PROD_W'(w_a) * PROD_W'(w_b);
        r_psq   <= i_cmd.sq;
        r_pstep <= i_cmd.step;
        r_pk    <= i_cmd.k;
        if (r_pv) begin
            if (r_psq) begin
                if (r_pk == 2'd0) begin
                    r_sum <= r_prod[SUM_W-1:0];
                end else begin
                    r_sum <= r_sum + r_prod[SUM_W-1:0];
                end
            end else if (r_pstep[2:1] == 2'd3) begin
                r_det <= r_pstep[0] ? r_det - ACC_W'(r_prod) : ACC_W'(r_prod);
            end else begin
                r_vec[r_pstep[2:1]] <= r_pstep[0] ? r_vec[r_pstep[2:1]] - ACC_W'(r_prod)
                                                  : ACC_W'(r_prod);
            end
        end

        // reduction to 31-bit magnitudes
        if (i_cmd.red_init) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_vec[i][ACC_W-1];
                r_mag[i] <= r_vec[i][ACC_W-1] ? -r_vec[i] : r_vec[i];
            end
        end else if (i_cmd.red_step) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= (|w_or[ACC_W-1:RED_W+4]) ? r_mag[i] >> 4 : r_mag[i] >> 1;
            end
        end

        // bit-pair square root
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_sum;
            r_root <= '0;
            r_bit  <= SUM_W'(1) << (SUM_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_rad >= w_trial) begin
                r_rad  <= r_rad - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        // restoring divide, rounded by half the length
        if (i_cmd.div_init) begin
            r_drem <= (DW'(r_mag[i_cmd.k][RED_W-1:0]) << UNIT_FRAC_BITS) + DW'(w_len >> 1);
            r_dsor <= DW'(w_len) << UNIT_FRAC_BITS;
            r_quo  <= '0;
            if (w_len == '0) r_degen <= 1'b1;
        end else if (i_cmd.div_step) begin
            if (w_ge) r_drem <= r_drem - r_dsor;
            r_quo  <= {r_quo[QW-2:0], w_ge};
            r_dsor <= r_dsor >> 1;
        end

        if (i_cmd.div_store) begin
            case (i_cmd.pass)
                PASS_T:  r_t[i_cmd.k] <= w_q;
                PASS_B:  r_b[i_cmd.k] <= w_q;
                PASS_N:  r_n[i_cmd.k] <= w_q;
                default: r_n[i_cmd.k] <= w_q;
            endcase
        end

        if (i_cmd.fix_sign) begin
            if (r_det == '0) r_degen <= 1'b1;
            if (r_det[ACC_W-1]) begin
                for (int i = 0; i < 3; i++) begin
                    r_t[i] <= -r_t[i];
                    r_b[i] <= -r_b[i];
                end
            end
        end

        if (i_cmd.out_load) begin
            if (r_degen) begin
                r_frame            <= '0;
                r_frame.degenerate <= 1'b1;
            end else begin
                r_frame.tangent_x  <= UNIT_W'(r_t[0]);
                r_frame.tangent_y  <= UNIT_W'(r_t[1]);
                r_frame.tangent_z  <= UNIT_W'(r_t[2]);
                r_frame.binormal_x <= UNIT_W'(r_b[0]);
                r_frame.binormal_y <= UNIT_W'(r_b[1]);
                r_frame.binormal_z <= UNIT_W'(r_b[2]);
                r_frame.normal_x   <= UNIT_W'(r_n[0]);
                r_frame.normal_y   <= UNIT_W'(r_n[1]);
                r_frame.normal_z   <= UNIT_W'(r_n[2]);
                r_frame.degenerate <= 1'b0;
            end
        end
    end

    // a unit component never exceeds one
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_store && w_len != '0) |-> (r_quo <= (QW'(1) << UNIT_FRAC_BITS)))
        else $error("quotient above unit scale");

    // the last product has landed before its sum is used
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.red_init || i_cmd.sqrt_init) |-> !r_pv)
        else $error("accumulator read with a product in flight");

endmodule

FILE: rtl/core/ttf_ctrl.sv
// controller: corner count and per-face sequencer
module ttf_ctrl #(
    parameter int UNIT_FRAC_BITS = ttf_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ttf_pkg::t_sts i_sts,
    output ttf_pkg::t_cmd o_cmd
);
    import ttf_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(UNIT_FRAC_BITS);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MWAIT,
        S_RINIT,
        S_RED,
        S_SQ,
        S_SWAIT,
        S_SINIT,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_DSTORE,
        S_SIGN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_cnt, n_cnt;
    t_pass            r_pass, n_pass;
    logic [2:0]       r_step, n_step;
    logic [1:0]       r_k, n_k;
    logic [CNT_W-1:0] r_iter, n_iter;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_step      = r_step;
        n_k         = r_k;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.corner = r_cnt;
        o_cmd.pass   = r_pass;
        o_cmd.step   = r_step;
        o_cmd.k      = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (r_cnt == CORNER_LAST) begin
                        n_cnt   = '0;
                        n_pass  = PASS_T;
                        n_step  = '0;
                        n_state = S_MUL;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = r_step + 3'd1;
                if (r_step == ((r_pass == PASS_T) ? STEP_T_LAST : STEP_LAST)) begin
                    n_state = S_MWAIT;
                end
            end
            S_MWAIT: n_state = S_RINIT;
            S_RINIT: begin
                o_cmd.red_init = 1'b1;
                n_state        = S_RED;
            end
            S_RED: begin
                if (i_sts.red_done) begin
                    n_k     = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.red_step = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                if (r_k == COMP_LAST) begin
                    n_state = S_SWAIT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_SWAIT: n_state = S_SINIT;
            S_SINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_iter          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == SQRT_LAST) begin
                    n_k     = '0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_iter         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == DIV_LAST) n_state = S_DSTORE;
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                if (r_k == COMP_LAST) begin
                    case (r_pass)
                        PASS_T: begin
                            n_pass  = PASS_B;
                            n_step  = '0;
                            n_state = S_MUL;
                        end
                        PASS_B:  n_state = S_SIGN;
                        PASS_N:  n_state = S_DONE;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_DINIT;
                end
            end
            S_SIGN: begin
                o_cmd.fix_sign = 1'b1;
                n_pass         = PASS_N;
                n_step         = '0;
                n_state        = S_MUL;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= PASS_T;
            r_step      <= '0;
            r_k         <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_step      <= n_step;
            r_k         <= n_k;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CORNER_LAST)
        else $error("corner count out of range");

    a_face_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_cnt == CORNER_LAST) |=>
            (r_state == S_MUL && r_pass == PASS_T && r_step == '0))
        else $error("third corner did not start a face");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_load_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_pass == PASS_N))
        else $error("result loaded before the normal pass");

endmodule

FILE: rtl/core/triangle_tangent_frame.sv
// top level of the per-face tangent, binormal and normal block
//
//  channel  | dir | item                          | accepted when
//  ---------+-----+-------------------------------+-----------------------
//  i_vtx    | in  | position and uv, Q16.16       | i_vtx.valid & ready
//  o_frm    | out | t, b, n in Q1.UNIT_FRAC_BITS  | o_frm.valid & ready
//
// a vertex that opens or continues a face is taken as soon as it is offered while the block is idle
// the third vertex of a face occupies the block for three passes, each using
//   the one multiplier, a bit-pair square root and three restoring divides
// the reduction shifter lengthens each of the first two passes, more so for
//   a wider edge span
// the finished frame sits in an output register; the next face's vertices
//   are taken while it waits, a new frame waits only if that slot is full
// synchronous active-low reset clears the corner count and the sequencer
module triangle_tangent_frame #(
    parameter int UNIT_FRAC_BITS = ttf_pkg::UNIT_FRAC_BITS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    ttf_vtx_if.sink   i_vtx,
    ttf_frm_if.source o_frm
);
    import ttf_pkg::*;

    t_vertex w_vtx;
    t_frame  w_frame;
    t_cmd    w_cmd;
    t_sts    w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    // vertex payload bundled for the datapath
    assign w_vtx.pos_x = i_vtx.pos_x;
    assign w_vtx.pos_y = i_vtx.pos_y;
    assign w_vtx.pos_z = i_vtx.pos_z;
    assign w_vtx.tex_u = i_vtx.tex_u;
    assign w_vtx.tex_v = i_vtx.tex_v;
    assign i_vtx.ready = w_in_ready;

    // sequencer: corner count, pass order and output slot
    ttf_ctrl #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_frm.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic: edges, products, reduction, root and divides
    ttf_dp #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_vtx   (w_vtx),
        .o_sts   (w_sts),
        .o_frame (w_frame)
    );

    // frame item straight from the output register
    assign o_frm.valid      = w_out_valid;
    assign o_frm.tangent_x  = w_frame.tangent_x;
    assign o_frm.tangent_y  = w_frame.tangent_y;
    assign o_frm.tangent_z  = w_frame.tangent_z;
    assign o_frm.binormal_x = w_frame.binormal_x;
    assign o_frm.binormal_y = w_frame.binormal_y;
    assign o_frm.binormal_z = w_frame.binormal_z;
    assign o_frm.normal_x   = w_frame.normal_x;
    assign o_frm.normal_y   = w_frame.normal_y;
    assign o_frm.normal_z   = w_frame.normal_z;
    assign o_frm.degenerate = w_frame.degenerate;

endmodule

FILE: sim/tb_triangle_tangent_frame.sv
// testbench for the triangle tangent frame block: directed and random faces, checked by a predictor
module tb_triangle_tangent_frame;
    import ttf_pkg::*;

    localparam int  UFB         = UNIT_FRAC_BITS_DEF;
    localparam int  RANDOM_VTX  = 1600;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  TAIL_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic signed [127:0] wide3_t [3];
    typedef longint vec3_t [3];

    logic i_clk;
    logic i_rst_n;

    ttf_vtx_if vtx ();
    ttf_frm_if frm ();

    triangle_tangent_frame dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .o_frm   (frm)
    );

    // predictor state: held corners of the open face
    t_vertex held_corner [2];
    int      corners_held;
    t_frame  frames_due [$];

    int     fail_count;
    int     vtx_sent;
    int     frames_seen;
    int     degenerate_seen;
    longint cycle_count;

    // sender burst shaping and receiver hold-off request
    int burst_left;
    int hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, frames_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic signed [127:0] widen(longint x);
        logic signed [127:0] w;
        w = x;
        return w;
    endfunction

    // bring three exact values below 2^31 by a common truncating shift
    function automatic void shrink3(input wide3_t w, output vec3_t o);
        logic [127:0] m [3];
        int bits, s;
        bits = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = w[i] < 0 ? -w[i] : w[i];
            for (int b = 127; b >= 0; b--) begin
                if (m[i][b] && b + 1 > bits) bits = b + 1;
            end
        end
        s = bits > 31 ? bits - 31 : 0;
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'(m[i] >> s);
            if (w[i] < 0) o[i] = -o[i];
        end
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // unit vector with rounded division; zero length gives 0
    function automatic bit to_unit(input vec3_t c, output vec3_t o);
        logic [63:0] sum, len, mag, q;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag = c[i] < 0 ? -c[i] : c[i];
            sum = sum + mag * mag;
        end
        len = root_floor(sum);
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag = c[i] < 0 ? -c[i] : c[i];
            q = ((mag << UFB) + (len >> 1)) / len;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic t_frame face_frame(t_vertex a, t_vertex b, t_vertex c);
        vec3_t  e1, e2, tr, br, t, bn, nr, n;
        longint du1, dv1, du2, dv2;
        logic signed [127:0] det;
        wide3_t tw, bw;
        bit     ok;
        t_frame f;
        e1[0] = longint'(b.pos_x) - longint'(a.pos_x);
        e1[1] = longint'(b.pos_y) - longint'(a.pos_y);
        e1[2] = longint'(b.pos_z) - longint'(a.pos_z);
        e2[0] = longint'(c.pos_x) - longint'(a.pos_x);
        e2[1] = longint'(c.pos_y) - longint'(a.pos_y);
        e2[2] = longint'(c.pos_z) - longint'(a.pos_z);
        du1 = longint'(b.tex_u) - longint'(a.tex_u);
        dv1 = longint'(b.tex_v) - longint'(a.tex_v);
        du2 = longint'(c.tex_u) - longint'(a.tex_u);
        dv2 = longint'(c.tex_v) - longint'(a.tex_v);
        det = widen(du1) * widen(dv2) - widen(du2) * widen(dv1);
        for (int i = 0; i < 3; i++) begin
            tw[i] = widen(dv2) * widen(e1[i]) - widen(dv1) * widen(e2[i]);
            bw[i] = widen(du1) * widen(e2[i]) - widen(du2) * widen(e1[i]);
        end
        shrink3(tw, tr);
        shrink3(bw, br);
        ok = det != 0;
        if (ok) ok = to_unit(tr, t);
        if (ok) ok = to_unit(br, bn);
        // 1/det scaling only survives normalising as its sign
        if (ok && det < 0) begin
            for (int i = 0; i < 3; i++) begin
                t[i] = -t[i];
                bn[i] = -bn[i];
            end
        end
        if (ok) begin
            nr[0] = t[1] * bn[2] - t[2] * bn[1];
            nr[1] = t[2] * bn[0] - t[0] * bn[2];
            nr[2] = t[0] * bn[1] - t[1] * bn[0];
            ok = to_unit(nr, n);
        end
        f = '0;
        if (ok) begin
            f.tangent_x  = t[0][15:0];
            f.tangent_y  = t[1][15:0];
            f.tangent_z  = t[2][15:0];
            f.binormal_x = bn[0][15:0];
            f.binormal_y = bn[1][15:0];
            f.binormal_z = bn[2][15:0];
            f.normal_x   = n[0][15:0];
            f.normal_y   = n[1][15:0];
            f.normal_z   = n[2][15:0];
        end
        f.degenerate = !ok;
        return f;
    endfunction

    // ---------------- checking ----------------

    task automatic report(string what, int got, int want);
        $display("mismatch at frame %0d: %s got %0d expected %0d",
                 frames_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame got, want;
        if (i_rst_n && frm.valid && frm.ready) begin
            got.tangent_x  = frm.tangent_x;
            got.tangent_y  = frm.tangent_y;
            got.tangent_z  = frm.tangent_z;
            got.binormal_x = frm.binormal_x;
            got.binormal_y = frm.binormal_y;
            got.binormal_z = frm.binormal_z;
            got.normal_x   = frm.normal_x;
            got.normal_y   = frm.normal_y;
            got.normal_z   = frm.normal_z;
            got.degenerate = frm.degenerate;
            if (frames_due.size() == 0) begin
                $display("frame %0d arrived with none expected", frames_seen);
                fail_count++;
            end else begin
                want = frames_due.pop_front();
                if (got.tangent_x != want.tangent_x)
                    report("tangent_x", got.tangent_x, want.tangent_x);
                if (got.tangent_y != want.tangent_y)
                    report("tangent_y", got.tangent_y, want.tangent_y);
                if (got.tangent_z != want.tangent_z)
                    report("tangent_z", got.tangent_z, want.tangent_z);
                if (got.binormal_x != want.binormal_x)
                    report("binormal_x", got.binormal_x, want.binormal_x);
                if (got.binormal_y != want.binormal_y)
                    report("binormal_y", got.binormal_y, want.binormal_y);
                if (got.binormal_z != want.binormal_z)
                    report("binormal_z", got.binormal_z, want.binormal_z);
                if (got.normal_x != want.normal_x)
                    report("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y != want.normal_y)
                    report("normal_y", got.normal_y, want.normal_y);
                if (got.normal_z != want.normal_z)
                    report("normal_z", got.normal_z, want.normal_z);
                if (got.degenerate != want.degenerate)
                    report("degenerate", got.degenerate, want.degenerate);
                if (want.degenerate) degenerate_seen++;
            end
            frames_seen++;
        end
    end

    // ---------------- receiver ----------------

    // stalls in random modes, each held for a random stretch; a hold-off request wins
    initial begin
        int mode, mode_left;
        frm.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                frm.ready = 1'b0;
                hold_request--;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 400);
                end
                mode_left--;
                case (mode)
                    0: frm.ready = 1'b1;
                    1: frm.ready = $urandom_range(0, 1);
                    2: frm.ready = ($urandom_range(0, 7) == 0);
                    default: frm.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ---------------- sender ----------------

    // offer one vertex, with burst gaps; valid stays high between back-to-back items
    task automatic send_vertex(t_vertex v);
        if (burst_left == 0) begin
            vtx.valid = 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 40) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        vtx.pos_x = v.pos_x;
        vtx.pos_y = v.pos_y;
        vtx.pos_z = v.pos_z;
        vtx.tex_u = v.tex_u;
        vtx.tex_v = v.tex_v;
        vtx.valid = 1'b1;
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        // item taken: advance the corner store of the predictor
        if (corners_held < 2) begin
            held_corner[corners_held] = v;
            corners_held++;
        end else begin
            frames_due.push_back(face_frame(held_corner[0], held_corner[1], v));
            corners_held = 0;
        end
        vtx_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_vertex make_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z, logic signed [31:0] u,
                                            logic signed [31:0] v);
        t_vertex r;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        r.tex_u = u;
        r.tex_v = v;
        return r;
    endfunction

    function automatic logic signed [31:0] any_coord(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function automatic t_vertex any_vertex(int style);
        return make_vertex(any_coord(style), any_coord(style), any_coord(style),
                           any_coord(style), any_coord(style));
    endfunction

    task automatic wait_for_drain();
        vtx.valid = 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_faces();
        localparam logic signed [31:0] ONE  = 32'sh0001_0000;
        localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] NMAX = 32'sh8000_0000;
        // unit right triangle, positive determinant
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(ONE, 0, 0, ONE, 0));
        send_vertex(make_vertex(0, ONE, 0, 0, ONE));
        // mirrored uv, negative determinant
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(ONE, 0, 0, 0, ONE));
        send_vertex(make_vertex(0, ONE, 0, ONE, 0));
        // all zero: zero determinant
        repeat (3) send_vertex(make_vertex(0, 0, 0, 0, 0));
        // uv spread but one position for all corners: zero tangent length
        send_vertex(make_vertex(ONE, ONE, ONE, 0, 0));
        send_vertex(make_vertex(ONE, ONE, ONE, ONE, 0));
        send_vertex(make_vertex(ONE, ONE, ONE, 0, ONE));
        // collinear uv with a real triangle
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(ONE, 0, 0, ONE, ONE));
        send_vertex(make_vertex(0, ONE, 0, -ONE, -ONE));
        // full-range extremes stretch every difference and the reduction shift
        send_vertex(make_vertex(NMAX, NMAX, NMAX, NMAX, NMAX));
        send_vertex(make_vertex(PMAX, NMAX, PMAX, PMAX, NMAX));
        send_vertex(make_vertex(NMAX, PMAX, PMAX, NMAX, PMAX));
        send_vertex(make_vertex(PMAX, PMAX, PMAX, PMAX, PMAX));
        send_vertex(make_vertex(NMAX, PMAX, NMAX, NMAX, PMAX));
        send_vertex(make_vertex(PMAX, NMAX, NMAX, PMAX, PMAX));
        // parallel tangent and binormal: zero normal
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(ONE, 0, 0, ONE, 0));
        send_vertex(make_vertex(2 * ONE, 0, 0, 0, ONE));
        wait_for_drain();
    endtask

    // mostly genuine faces of random scale, with repeated corners mixed in
    task automatic test_random_faces(int count);
        t_vertex last;
        int style;
        last = any_vertex(1);
        for (int i = 0; i < count; i++) begin
            style = $urandom_range(0, 9);
            if (style == 9) begin
                send_vertex(last);
            end else begin
                last = any_vertex(style < 4 ? 0 : style < 7 ? 1 : style < 8 ? 3 : 2);
                send_vertex(last);
            end
        end
    endtask

    // receiver stalls for a long stretch while vertices keep coming
    task automatic test_output_hold_off();
        hold_request = HOLD_CYCLES;
        burst_left = 1000;
        for (int i = 0; i < 60; i++) send_vertex(any_vertex(i % 2));
        wait_for_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        vtx.valid = 1'b0;
        vtx.pos_x = '0;
        vtx.pos_y = '0;
        vtx.pos_z = '0;
        vtx.tex_u = '0;
        vtx.tex_v = '0;
        corners_held = 0;
        fail_count = 0;
        vtx_sent = 0;
        frames_seen = 0;
        degenerate_seen = 0;
        cycle_count = 0;
        burst_left = 0;
        hold_request = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_faces();
        test_random_faces(RANDOM_VTX / 2);
        test_output_hold_off();
        test_random_faces(RANDOM_VTX / 2);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d vertices sent, %0d frames checked, %0d of them degenerate",
                 vtx_sent, frames_seen, degenerate_seen);
        $display("covered extremes, sign of det, zero lengths and a long output stall");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
